@@ hw/rtl/indexed_max_heap_top_assert.svh @@
// Assertion macros for the indexed max-heap block.
// Used by indexed_max_heap_top.sv; no other dependencies.
`ifndef INDEXED_MAX_HEAP_TOP_ASSERT_SVH
`define INDEXED_MAX_HEAP_TOP_ASSERT_SVH
// implication checked at every clock edge outside reset
`define IMH_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define IMH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ hw/rtl/imh_pkg.sv @@
// Shared types and codes for the indexed max-heap block.
// No dependencies; used by every module of the block.
`default_nettype none
package imh_pkg;
   localparam int KEY_W  = 32;
   localparam int ITEM_W = 10;
   localparam int ITEMS  = 1 << ITEM_W;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_POP = 2'd1,
      ACT_DEC = 2'd2,
      ACT_NOP = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_DUP      = 3'd3,
      ST_DEC_SKIP = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAPRD,   // reverse map read for the request item
      S_DECIDE,  // checks, first write
      S_LASTRD,  // pop: read last entry
      S_MOVE,    // pop: move last to root
      S_RD_A,    // sift: read first operand
      S_RD_B,    // sift: read second operand
      S_CMP,     // sift: compare in shared unit
      S_CMP2,    // sift down: compare right child with left child or parent
      S_SWAP_A,  // write first slot
      S_SWAP_B,  // write second slot
      S_OUT      // result held until taken
   } state_type;

   // request from sequencer to heap store
   typedef struct packed {
      logic                   wr;
      logic [15:0]            addr;
      logic signed [KEY_W-1:0] key;
      logic [ITEM_W-1:0]      item;
   } heap_cmd_type;
endpackage
`default_nettype wire

@@ hw/rtl/imh_store.sv @@
// Heap key/item memory: one port, registered read data.
// Depends on imh_pkg.
`default_nettype none
module imh_store #(
   parameter int SLOTS = 1024,
   parameter int AW    = 10
) (
   input  wire logic                       clock,
   input  wire imh_pkg::heap_cmd_type      cmd,
   output logic signed [imh_pkg::KEY_W-1:0] rd_key,
   output logic [imh_pkg::ITEM_W-1:0]      rd_item
);
   import imh_pkg::*;
   logic [KEY_W+ITEM_W-1:0] mem [SLOTS];
   logic [AW-1:0] a;
   assign a = cmd.addr[AW-1:0];
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[a] <= {cmd.key, cmd.item};
      end
      {rd_key, rd_item} <= mem[a];
   end
endmodule
`default_nettype wire

@@ hw/rtl/imh_posmap.sv @@
// Reverse map from item to heap position; each entry holds a present flag and a position.
// Cleared entry by entry after reset, busy while clearing. Depends on imh_pkg.
`default_nettype none
module imh_posmap #(
   parameter int PW = 11
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [imh_pkg::ITEM_W-1:0] addr,
   input  wire logic                      wr,
   input  wire logic                      wr_valid,
   input  wire logic [PW-1:0]             wr_pos,
   output logic                           rd_valid,
   output logic [PW-1:0]                  rd_pos,
   output logic                           busy
);
   import imh_pkg::*;
   logic [PW:0] mem [ITEMS];          // {present, position}
   logic [PW:0] rd_ff;
   logic [ITEM_W-1:0] clr_ff;
   logic busy_ff;

   // clearing pass: one entry per cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == ITEM_W'(ITEMS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr) begin
         mem[addr] <= {wr_valid, wr_pos};
      end
      rd_ff <= mem[addr];
   end

   assign rd_valid = rd_ff[PW];
   assign rd_pos   = rd_ff[PW-1:0];
   assign busy     = busy_ff;
endmodule
`default_nettype wire

@@ hw/rtl/indexed_max_heap_top.sv @@
// Indexed binary max-heap with decrease-key: sequencer and shared comparator.
// Depends on imh_pkg, imh_store, imh_posmap and the assertion header.
//
//  channel | dir | tdata fields (low first)          | tuser
//  req_    | in  | key[31:0] item[41:32] pad to 48   | action[1:0]
//  rsp_    | out | out_key[31:0] out_item[41:32]     | status[2:0] occupancy[13:3]
//                  pad to 48
//
// One transfer at a time; req_tready is high only when idle. After acceptance the
// look-up and checks run in S_MAPRD and S_DECIDE; a pop then moves the last pair
// to the root in S_LASTRD and S_MOVE. Each sift level reads two operands (S_RD_A,
// S_RD_B), compares (S_CMP, plus S_CMP2 for sift-down) and, if needed, swaps
// (S_SWAP_A, S_SWAP_B); depth log2(SLOTS) sets the worst case.
// Reset is synchronous and clears the count at once; the reverse map is then
// cleared one entry a cycle with req_tready held low. The result waits in a register
// until rsp_tready; nothing new is accepted until it is taken.
`default_nettype none
module indexed_max_heap_top #(
   parameter int SLOTS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // key, item, zero pad
   input  wire logic [1:0]  req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // out_key, out_item, zero pad
   output logic [13:0]      rsp_tuser    // status, occupancy
);
   import imh_pkg::*;
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = $clog2(SLOTS + 1);

   state_type st_ff, st_in;
   action_type act_ff;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [ITEM_W-1:0] item_ff, item_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] p_ff, p_in;       // current position
   logic [PW-1:0] c_ff, c_in;       // partner position
   logic up_ff, up_in;              // sift direction
   logic lgt_ff, lgt_in;            // sift down: left child above parent
   logic signed [KEY_W-1:0] ak_ff, ak_in, bk_ff, bk_in;
   logic [ITEM_W-1:0] ai_ff, ai_in, bi_ff, bi_in;
   logic signed [KEY_W-1:0] ok_ff, ok_in;
   logic [ITEM_W-1:0] oi_ff, oi_in;
   status_type sts_ff, sts_in;

   heap_cmd_type cmd;
   logic signed [KEY_W-1:0] rd_key;
   logic [ITEM_W-1:0] rd_item;
   logic [ITEM_W-1:0] map_addr;
   logic map_wr, map_wv, map_rv, map_busy;
   logic [PW-1:0] map_wpos, map_rpos;

   imh_store #(.SLOTS(SLOTS), .AW(AW)) u_store (
      .clock(clock), .cmd(cmd), .rd_key(rd_key), .rd_item(rd_item));
   imh_posmap #(.PW(PW)) u_map (
      .clock(clock), .reset(reset), .addr(map_addr), .wr(map_wr),
      .wr_valid(map_wv), .wr_pos(map_wpos), .rd_valid(map_rv), .rd_pos(map_rpos),
      .busy(map_busy));

   // shared signed comparator: a > b
   logic signed [KEY_W-1:0] cmp_a, cmp_b;
   logic gt;
   assign gt = cmp_a > cmp_b;

   logic [PW:0] lchild;
   assign lchild = {p_ff, 1'b1};
   logic [PW-1:0] parent;
   assign parent = (p_ff - 1'b1) >> 1;
   logic r_ok;                      // right child inside the heap
   assign r_ok = (c_ff + 1'b1) < cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
      act_ff <= (st_ff == S_IDLE) ? action_type'(req_tuser) : act_ff;
      key_ff <= key_in; item_ff <= item_in; p_ff <= p_in; c_ff <= c_in;
      up_ff <= up_in; ak_ff <= ak_in; bk_ff <= bk_in; ai_ff <= ai_in;
      bi_ff <= bi_in; ok_ff <= ok_in; oi_ff <= oi_in; sts_ff <= sts_in;
      lgt_ff <= lgt_in;
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE:   if (req_tvalid && req_tready) st_in = S_MAPRD;
         S_MAPRD:  st_in = S_DECIDE;
         S_DECIDE: begin
            st_in = S_OUT;
            case (act_ff)
               ACT_ADD: if (cnt_ff < PW'(SLOTS) && !map_rv && cnt_ff != '0) st_in = S_RD_A;
               ACT_POP: if (cnt_ff > PW'(1)) st_in = S_LASTRD;
               ACT_DEC: if (map_rv && map_rpos < cnt_ff && gt)
                  st_in = S_RD_A;
               default: st_in = S_OUT;
            endcase
         end
         S_LASTRD: st_in = S_MOVE;
         S_MOVE:   st_in = S_RD_A;
         S_RD_A: begin
            if (up_ff) st_in = (p_ff == '0) ? S_OUT : S_RD_B;
            else st_in = ({1'b0, lchild} < {1'b0, cnt_ff}) ? S_RD_B : S_OUT;
         end
         S_RD_B:   st_in = S_CMP;
         S_CMP: begin
            if (up_ff) st_in = gt ? S_SWAP_A : S_OUT;
            else st_in = S_CMP2;
         end
         S_CMP2:   st_in = (r_ok ? (lgt_ff || gt) : lgt_ff) ? S_SWAP_A : S_OUT;
         S_SWAP_A: st_in = S_SWAP_B;
         S_SWAP_B: st_in = S_RD_A;
         S_OUT:    if (rsp_tready) st_in = S_IDLE;
         default:  st_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      key_in = key_ff; item_in = item_ff; cnt_in = cnt_ff; p_in = p_ff; c_in = c_ff;
      up_in = up_ff; ak_in = ak_ff; bk_in = bk_ff; ai_in = ai_ff; bi_in = bi_ff;
      ok_in = ok_ff; oi_in = oi_ff; sts_in = sts_ff; lgt_in = lgt_ff;
      cmd = '{wr: 1'b0, addr: 16'(p_ff), key: key_ff, item: item_ff};
      map_addr = item_ff; map_wr = 1'b0; map_wv = 1'b1; map_wpos = p_ff;
      cmp_a = bk_ff; cmp_b = ak_ff;
      case (st_ff)
         S_IDLE: begin
            key_in  = req_tdata[KEY_W-1:0];
            item_in = req_tdata[KEY_W+ITEM_W-1:KEY_W];
            map_addr = req_tdata[KEY_W+ITEM_W-1:KEY_W];
            cmd.addr = '0;          // root, for pop
            ok_in = '0; oi_in = '0; sts_in = ST_DONE;
         end
         S_MAPRD: begin
            // map read done; for decrease fetch the entry at its position
            cmd.addr = (act_ff == ACT_DEC) ? 16'(map_rpos) : 16'd0;
         end
         S_DECIDE: begin
            // decrease: stored key above the new one
            cmp_a = rd_key; cmp_b = key_ff;
            case (act_ff)
               ACT_ADD: begin
                  if (cnt_ff >= PW'(SLOTS)) sts_in = ST_FULL;
                  else if (map_rv) sts_in = ST_DUP;
                  else begin
                     cmd = '{wr: 1'b1, addr: 16'(cnt_ff), key: key_ff, item: item_ff};
                     map_wr = 1'b1; map_wpos = cnt_ff;
                     p_in = cnt_ff; cnt_in = cnt_ff + 1'b1; up_in = 1'b1;
                  end
               end
               ACT_POP: begin
                  if (cnt_ff == '0) sts_in = ST_EMPTY;
                  else begin
                     ok_in = rd_key; oi_in = rd_item;
                     map_addr = rd_item; map_wr = 1'b1; map_wv = 1'b0;
                     cnt_in = cnt_ff - 1'b1; p_in = '0; up_in = 1'b0;
                  end
               end
               ACT_DEC: begin
                  if (!(map_rv && map_rpos < cnt_ff && gt))
                     sts_in = ST_DEC_SKIP;
                  else begin
                     cmd = '{wr: 1'b1, addr: 16'(map_rpos), key: key_ff,
                             item: item_ff};
                     p_in = map_rpos; up_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         S_LASTRD: cmd.addr = 16'(cnt_ff);
         S_MOVE: begin
            cmd = '{wr: 1'b1, addr: 16'd0, key: rd_key, item: rd_item};
            map_addr = rd_item; map_wr = 1'b1; map_wpos = '0;
         end
         S_RD_A: begin
            // sift up: a = parent, b = current. down: a = parent(cur), b = left
            if (up_ff) begin
               cmd.addr = 16'(parent); c_in = parent;
            end else begin
               cmd.addr = 16'(p_ff); c_in = lchild[PW-1:0];
            end
         end
         S_RD_B: begin
            ak_in = rd_key; ai_in = rd_item;
            cmd.addr = up_ff ? 16'(p_ff) : 16'(c_ff);
         end
         S_CMP: begin
            bk_in = rd_key; bi_in = rd_item;
            cmp_a = rd_key; cmp_b = ak_ff;  // up: cur > parent; down: left > parent
            lgt_in = gt;
            if (!up_ff) begin
               // fetch right child when present
               cmd.addr = 16'(c_ff + 1'b1);
            end
         end
         S_CMP2: begin
            // left above parent: left vs right picks the child, a swap follows.
            // otherwise only a right child above the parent can swap.
            if (lgt_ff) begin
               cmp_a = bk_ff; cmp_b = rd_key;
            end else begin
               cmp_a = rd_key; cmp_b = ak_ff;
            end
            if (r_ok && (lgt_ff ? !gt : gt)) begin
               bk_in = rd_key; bi_in = rd_item; c_in = c_ff + 1'b1;
            end
         end
         S_SWAP_A: begin
            // parent slot (current for down, partner for up) takes the larger
            if (up_ff) begin
               cmd = '{wr: 1'b1, addr: 16'(c_ff), key: bk_ff, item: bi_ff};
               map_addr = bi_ff; map_wr = 1'b1; map_wpos = c_ff;
            end else begin
               cmd = '{wr: 1'b1, addr: 16'(p_ff), key: bk_ff, item: bi_ff};
               map_addr = bi_ff; map_wr = 1'b1; map_wpos = p_ff;
            end
         end
         S_SWAP_B: begin
            if (up_ff) begin
               cmd = '{wr: 1'b1, addr: 16'(p_ff), key: ak_ff, item: ai_ff};
               map_addr = ai_ff; map_wr = 1'b1; map_wpos = p_ff;
            end else begin
               cmd = '{wr: 1'b1, addr: 16'(c_ff), key: ak_ff, item: ai_ff};
               map_addr = ai_ff; map_wr = 1'b1; map_wpos = c_ff;
            end
            p_in = c_ff;
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (st_ff == S_IDLE) && !map_busy;
      rsp_tvalid = (st_ff == S_OUT);
      rsp_tdata  = {6'd0, oi_ff, ok_ff};
      rsp_tuser  = {11'(cnt_ff), sts_ff};
   end

`include "indexed_max_heap_top_assert.svh"
   `IMH_ASSERT_IMPL(a_count_bound, 1'b1, cnt_ff <= PW'(SLOTS), "count above capacity")
   `IMH_ASSERT_IMPL(a_one_side, rsp_tvalid, !req_tready, "both sides open at once")
   `IMH_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tuser), "result dropped while stalled")
endmodule
`default_nettype wire

@@ tb/indexed_max_heap_top_tb.sv @@
// Self-checking bench for the indexed max-heap: queued stimulus, handshake driver and monitor,
// with a behavioural heap predicting every result transfer.
// Depends on imh_pkg and indexed_max_heap_top.
`timescale 1ns / 100ps
`default_nettype none
module indexed_max_heap_top_tb;
   import imh_pkg::*;

   localparam int HEAP_SLOTS = 1024;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct packed {
      action_type       action;
      logic signed [31:0] key;
      logic [9:0]       item;
   } heap_req_type;

   typedef struct packed {
      logic signed [31:0] out_key;
      logic [9:0]       out_item;
      status_type       status;
      logic [10:0]      occupancy;
   } heap_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;   // key[31:0], item[41:32], zero pad
   logic [1:0]  req_tuser = '0;   // action
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // out_key[31:0], out_item[41:32], zero pad
   logic [13:0] rsp_tuser;        // status[2:0], occupancy[13:3]

   indexed_max_heap_top #(.SLOTS(HEAP_SLOTS)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   logic signed [31:0] mdl_keys [HEAP_SLOTS];
   logic [9:0]         mdl_items [HEAP_SLOTS];
   bit                 mdl_present [ITEMS];
   int unsigned        mdl_pos [ITEMS];
   int unsigned        mdl_count;

   // list of items added so far, lets the generator pick decrease targets and duplicate adds
   logic [9:0] live_items [$];

   heap_req_type pending_reqs [$];
   heap_rsp_type expected_rsps [$];
   int        fail_count = 0;
   bit        hold_sender = 1'b0;
   bit        stim_done = 1'b0;

   function automatic void heap_swap(int unsigned a, int unsigned b);
      logic signed [31:0] tk;
      logic [9:0] ti;
      tk = mdl_keys[a]; ti = mdl_items[a];
      mdl_keys[a] = mdl_keys[b]; mdl_items[a] = mdl_items[b];
      mdl_keys[b] = tk; mdl_items[b] = ti;
      mdl_pos[mdl_items[a]] = a;
      mdl_pos[mdl_items[b]] = b;
   endfunction

   function automatic void heap_sift_down(int unsigned p);
      int unsigned l, r, c;
      l = 2 * p + 1;
      while (l < mdl_count) begin
         r = l + 1;
         c = (r >= mdl_count || mdl_keys[l] > mdl_keys[r]) ? l : r;
         if (mdl_keys[c] > mdl_keys[p]) begin
            heap_swap(p, c);
            p = c;
            l = 2 * p + 1;
         end else begin
            break;
         end
      end
   endfunction

   function automatic heap_rsp_type heap_apply(heap_req_type rq);
      heap_rsp_type rs;
      int unsigned n, p;
      rs = '0;
      rs.status = ST_DONE;
      case (rq.action)
         ACT_ADD: begin
            if (mdl_count >= HEAP_SLOTS) rs.status = ST_FULL;
            else if (mdl_present[rq.item]) rs.status = ST_DUP;
            else begin
               n = mdl_count;
               mdl_keys[n] = rq.key; mdl_items[n] = rq.item;
               mdl_present[rq.item] = 1'b1; mdl_pos[rq.item] = n;
               mdl_count++;
               while (n > 0) begin
                  p = (n - 1) / 2;
                  if (mdl_keys[p] < mdl_keys[n]) begin
                     heap_swap(p, n);
                     n = p;
                  end else begin
                     break;
                  end
               end
            end
         end
         ACT_POP: begin
            if (mdl_count == 0) rs.status = ST_EMPTY;
            else begin
               rs.out_key = mdl_keys[0];
               rs.out_item = mdl_items[0];
               mdl_present[mdl_items[0]] = 1'b0;
               mdl_count--;
               if (mdl_count > 0) begin
                  mdl_keys[0] = mdl_keys[mdl_count];
                  mdl_items[0] = mdl_items[mdl_count];
                  mdl_pos[mdl_items[0]] = 0;
                  heap_sift_down(0);
               end
            end
         end
         ACT_DEC: begin
            p = mdl_pos[rq.item];
            if (!mdl_present[rq.item] || p >= mdl_count || mdl_keys[p] <= rq.key)
               rs.status = ST_DEC_SKIP;
            else begin
               mdl_keys[p] = rq.key;
               heap_sift_down(p);
            end
         end
         default: ;
      endcase
      rs.occupancy = mdl_count[10:0];
      return rs;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   // generator-side shadow: tracks contents so decreases can target live items
   bit          gen_present [ITEMS];
   logic signed [31:0] gen_key [ITEMS];
   int unsigned gen_count = 0;

   function automatic logic signed [31:0] rand_key();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'(signed'($urandom_range(0, 6)) - 3);   // near zero, many ties
         3, 4: return 32'(signed'($urandom_range(0, 40)) << 16);
         default: return $urandom;
      endcase
   endfunction

   task automatic push_req(action_type act, logic signed [31:0] k, logic [9:0] it);
      heap_req_type rq;
      rq.action = act; rq.key = k; rq.item = it;
      pending_reqs.push_back(rq);
      // shadow only steers the generator; checking uses the predictor above
      case (act)
         ACT_ADD: if (gen_count < HEAP_SLOTS && !gen_present[it]) begin
            gen_present[it] = 1'b1; gen_key[it] = k; gen_count++;
            live_items.push_back(it);
         end
         ACT_POP: if (gen_count > 0) begin
            // popped item unknown here; shadow count only
            gen_count--;
         end
         ACT_DEC: if (gen_present[it] && gen_key[it] > k) gen_key[it] = k;
         default: ;
      endcase
   endtask

   task automatic add_fresh(logic signed [31:0] k);
      logic [9:0] it;
      int tries;
      tries = 0;
      it = 10'($urandom);
      while (gen_present[it] && tries < 2000) begin
         it = 10'($urandom); tries++;
      end
      push_req(ACT_ADD, k, it);
   endtask

   // ---------------------------------------------------------------- driver
   heap_req_type drv_cur;
   int        send_gap = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         // slot free (idle or previous transfer accepted this edge)
         if (req_tvalid) send_gap = pick_gap();
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (!hold_sender && pending_reqs.size() > 0) begin
            drv_cur = pending_reqs.pop_front();
            expected_rsps.push_back(heap_apply(drv_cur));
            req_tdata <= {6'b0, drv_cur.item, drv_cur.key};
            req_tuser <= drv_cur.action;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   heap_rsp_type got, want;
   int        sink_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_key = rsp_tdata[31:0];
            got.out_item = rsp_tdata[41:32];
            got.status = status_type'(rsp_tuser[2:0]);
            got.occupancy = rsp_tuser[13:3];
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transfer: key %0d item %0d",
                      got.out_key, got.out_item);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.out_key !== want.out_key) begin
                  $error("out_key: expected %0d, got %0d", want.out_key, got.out_key);
                  fail_count++;
               end
               if (got.out_item !== want.out_item) begin
                  $error("out_item: expected %0d, got %0d", want.out_item, got.out_item);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         want.occupancy, got.occupancy);
                  fail_count++;
               end
            end
            sink_gap = pick_gap();
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- cycle limit
   int unsigned cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("indexed_max_heap_top: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      int sel;
      logic [9:0] it;
      mdl_count = 0;
      for (int i = 0; i < ITEMS; i++) begin
         mdl_present[i] = 1'b0;
         mdl_pos[i] = 0;
         gen_present[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: pop on empty, extremes, ties, duplicate, decrease cases, unused action
      push_req(ACT_POP, 32'sd5, 10'd7);
      push_req(ACT_ADD, 32'sh7fffffff, 10'd0);
      push_req(ACT_ADD, 32'sh80000000, 10'd1023);
      push_req(ACT_ADD, 32'sh7fffffff, 10'd0);          // duplicate
      push_req(ACT_ADD, 32'sd100, 10'd512);
      push_req(ACT_ADD, 32'sd100, 10'd341);             // tie with sibling
      push_req(ACT_ADD, 32'sd100, 10'd682);
      push_req(ACT_DEC, 32'sd1, 10'd200);               // absent item
      push_req(ACT_DEC, 32'sd100, 10'd512);             // not smaller
      push_req(ACT_DEC, 32'sd200, 10'd512);             // larger
      push_req(ACT_DEC, 32'sh80000000, 10'd0);          // root to the bottom
      push_req(ACT_NOP, 32'shffffffff, 10'h3ff);
      for (int i = 0; i < 7; i++) push_req(ACT_POP, 32'sd0, 10'd0);
      push_req(ACT_DEC, 32'sd0, 10'd512);               // popped item, now absent

      // random: mostly valid adds, pops and decreases on live items
      for (int i = 0; i < 800; i++) begin
         if (i == 400) begin
            // drain fully before continuing
            wait (pending_reqs.size() == 0);
            hold_sender = 1'b1;
            wait (expected_rsps.size() == 0);
            hold_sender = 1'b0;
         end
         sel = $urandom_range(0, 99);
         if (sel < 45) add_fresh(rand_key());
         else if (sel < 70) push_req(ACT_POP, rand_key(), 10'($urandom));
         else if (sel < 88 && live_items.size() > 0) begin
            it = live_items[$urandom_range(0, live_items.size() - 1)];
            if (gen_present[it] && $urandom_range(0, 3) != 0)
               push_req(ACT_DEC, gen_key[it] - 32'($urandom_range(0, 1 << 18)), it);
            else
               push_req(ACT_DEC, rand_key(), it);
         end else if (sel < 94 && live_items.size() > 0) begin
            push_req(ACT_ADD, rand_key(),
                     live_items[$urandom_range(0, live_items.size() - 1)]);
         end else begin
            push_req(action_type'($urandom_range(0, 3)), rand_key(), 10'($urandom));
         end
      end

      // pop a run of maxima, ending on empty if the heap is small
      for (int i = 0; i < 40; i++) push_req(ACT_POP, 32'sd0, 10'd0);

      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_tvalid);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("indexed_max_heap_top: match");
      end else begin
         $display("indexed_max_heap_top: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire
